FILE: rtl/gwm_pkg.sv
// gwm_pkg: shared types and constants for the glob wildcard matcher.
// Used by gwm_cell, gwm_closure and glob_wildcard_matcher_unit.
package gwm_pkg;

    localparam int unsigned MAX_PATTERN_DEF = 64;

    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_SUBJECT = 2'd2,
        OP_EMPTY   = 2'd3
    } op_t;

    typedef struct packed {
        logic wen;
        logic restart;
        logic step;
    } cell_ctl_t;

    typedef struct packed {
        logic star;
        logic keep;
        logic adv;
    } cell_out_t;

endpackage

FILE: rtl/gwm_cell.sv
// gwm_cell: one pattern position, holds the pattern byte and its active bit.
// Depends on gwm_pkg.
module gwm_cell
    import gwm_pkg::*;
#(
    parameter int unsigned INDEX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic [7:0] ch,
    input  logic      enabled,
    input  logic      act_closed,
    input  logic      adv_in,
    output cell_out_t co,
    output logic      act
);

    localparam logic ACT_RST = (INDEX == 0);

    logic [7:0] pat_reg;
    logic       act_reg;
    logic       act_next;
    logic       hit;

    assign hit     = (pat_reg == QMARK_BYTE) || (pat_reg == ch);
    assign co.star = enabled && (pat_reg == STAR_BYTE);
    assign co.keep = act_closed && co.star;
    assign co.adv  = act_closed && enabled && !co.star && hit;
    assign act     = act_reg;

    always_comb
    begin
        act_next = act_reg;
        if (ctl.restart)
        begin
            act_next = ACT_RST;
        end
        else if (ctl.step)
        begin
            act_next = co.keep || adv_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_RST;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wen)
        begin
            pat_reg <= ch;
        end
    end

endmodule

FILE: rtl/gwm_closure.sv
// gwm_closure: star closure of the active set, done as one carry chain.
// Depends on gwm_pkg.
module gwm_closure
    import gwm_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic [MAX_PATTERN:0]   act_vec,
    input  logic [MAX_PATTERN-1:0] star_vec,
    output logic [MAX_PATTERN:0]   closed
);

    logic [MAX_PATTERN:0]   prop;
    logic [MAX_PATTERN:0]   gen;
    logic [MAX_PATTERN:0]   sum;
    logic [MAX_PATTERN:0]   carry;

    // generate at an active star, propagate along a run of stars
    assign prop   = {1'b0, star_vec};
    assign gen    = act_vec & prop;
    assign sum    = gen + prop;
    assign carry  = sum ^ gen ^ prop;
    assign closed = act_vec | carry;

endmodule

FILE: rtl/glob_wildcard_matcher_unit.sv
// glob_wildcard_matcher_unit: top level, row of pattern cells plus result stage.
// Depends on gwm_pkg, gwm_cell and gwm_closure.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------
//   request | in_valid  | in_stall  | op, ch, last
//   result  | out_valid | out_stall | matched, pattern_overflow
//
// Clear, append and non-final subject bytes do not stall the request channel.
// A final subject byte or empty query is done in two steps: the cell row steps, then
// the end check (closure carry chain plus a select by pattern length) loads
// the result register. in_stall is high from that request until its result is
// loaded, including any wait for a free result register.
// Reset leaves an empty pattern with position zero active.
module glob_wildcard_matcher_unit
    import gwm_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] ch,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       pattern_overflow
);

    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_PATTERN);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             pend_reg;
    logic             pend_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic             matched_next;
    logic             povf_reg;
    logic             povf_next;
    logic             act_n_reg;
    logic             act_n_next;

    logic             accept;
    logic             eval_fire;
    logic             restart;
    logic             step;
    logic             append;
    logic             has_room;
    op_t              op_code;

    logic [MAX_PATTERN:0]   act_vec;
    logic [MAX_PATTERN:0]   closed;
    logic [MAX_PATTERN-1:0] star_vec;
    cell_out_t              co [MAX_PATTERN];
    cell_ctl_t              ctl [MAX_PATTERN];

    assign op_code   = op_t'(op);
    assign in_stall  = pend_reg;
    assign accept    = in_valid && !in_stall;
    assign eval_fire = pend_reg && (!out_valid_reg || !out_stall);
    assign append    = accept && (op_code == OP_APPEND);
    assign has_room  = (len_reg != LEN_FULL);
    assign step      = accept && (op_code == OP_SUBJECT);
    assign restart   = (accept && (op_code != OP_SUBJECT)) || eval_fire;

    generate
        for (genvar g = 0; g < MAX_PATTERN; g++)
        begin : g_cell
            logic adv_in;

            if (g == 0)
            begin : g_first
                assign adv_in = 1'b0;
            end
            else
            begin : g_rest
                assign adv_in = co[g-1].adv;
            end

            assign ctl[g].wen     = append && has_room && (len_reg == LEN_W'(g));
            assign ctl[g].restart = restart;
            assign ctl[g].step    = step;
            assign star_vec[g]    = co[g].star;

            gwm_cell #(
                .INDEX (g)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl[g]),
                .ch         (ch),
                .enabled    (len_reg > LEN_W'(g)),
                .act_closed (closed[g]),
                .adv_in     (adv_in),
                .co         (co[g]),
                .act        (act_vec[g])
            );
        end
    endgenerate

    assign act_vec[MAX_PATTERN] = act_n_reg;

    gwm_closure #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_closure (
        .act_vec  (act_vec),
        .star_vec (star_vec),
        .closed   (closed)
    );

    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        povf_next      = povf_reg;
        act_n_next     = act_n_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (restart)
        begin
            act_n_next = 1'b0;
        end
        else if (step)
        begin
            act_n_next = co[MAX_PATTERN-1].adv;
        end

        if (accept)
        begin
            unique case (op_code)
                OP_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                OP_APPEND:
                begin
                    if (has_room)
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                OP_SUBJECT:
                begin
                    pend_next = last;
                end
                OP_EMPTY:
                begin
                    pend_next = 1'b1;
                end
                default:
                begin
                    pend_next = pend_reg;
                end
            endcase
        end

        if (eval_fire)
        begin
            pend_next      = 1'b0;
            out_valid_next = 1'b1;
            matched_next   = closed[len_reg] && !ovf_reg;
            povf_next      = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            act_n_reg     <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            act_n_reg     <= act_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        povf_reg    <= povf_next;
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = povf_reg;

`ifndef NO_ASSERTIONS
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_FULL)
        else $error("pattern length beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == LEN_FULL))
        else $error("overflow flag set with room left");

    a_restart_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        eval_fire |=> (act_vec == (MAX_PATTERN + 1)'(1)))
        else $error("active set not restarted after result");

    a_result_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(pend_reg))
        else $error("result without pending end check");

    a_overflow_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (eval_fire && ovf_reg) |=> !matched_reg)
        else $error("match reported with overflowed pattern");
`endif

endmodule

FILE: tb/gwm_match_checker.sv
// gwm_match_checker: watches both channels of the glob wildcard matcher, predicts each
// result from the accepted requests and compares it field by field.
// Depends on gwm_pkg for the opcodes, the wildcard bytes and the pattern capacity.
`timescale 1ns / 100ps
module gwm_match_checker
    import gwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] ch,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       matched,
    input  logic       pattern_overflow,
    output int         fail_count,
    output int         pending
);

    localparam int unsigned DEPTH = MAX_PATTERN_DEF;
    localparam logic [DEPTH:0] START = {{DEPTH{1'b0}}, 1'b1};

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    verdict_t       expected_verdicts[$];
    logic [7:0]     pat_mem[DEPTH];
    int unsigned    pat_len;
    logic [DEPTH:0] live;
    logic           ovf;

    function automatic logic [DEPTH:0] close_stars(input logic [DEPTH:0] s);
        logic [DEPTH:0] r;
        r = s;
        for (int i = 0; i < pat_len; i++)
            if (r[i] && pat_mem[i] == STAR_BYTE)
                r[i + 1] = 1'b1;
        return r;
    endfunction

    function automatic logic [DEPTH:0] advance_live(input logic [7:0] c);
        logic [DEPTH:0] cur;
        logic [DEPTH:0] nxt;
        cur = close_stars(live);
        nxt = '0;
        for (int i = 0; i < pat_len; i++)
            if (cur[i])
            begin
                if (pat_mem[i] == STAR_BYTE)
                    nxt[i] = 1'b1;
                else if (pat_mem[i] == QMARK_BYTE || pat_mem[i] == c)
                    nxt[i + 1] = 1'b1;
            end
        return nxt;
    endfunction

    function automatic verdict_t subject_verdict(input logic [DEPTH:0] s);
        logic [DEPTH:0] c;
        verdict_t       v;
        c = close_stars(s);
        v.matched  = c[pat_len] && !ovf;
        v.overflow = ovf;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            expected_verdicts.delete();
            pat_len    = 0;
            ovf        = 1'b0;
            live       = START;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch("result with no request waiting for one");
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (matched !== want.matched)
                        report_mismatch($sformatf("matched %b, expected %b",
                                                  matched, want.matched));
                    if (pattern_overflow !== want.overflow)
                        report_mismatch($sformatf("pattern_overflow %b, expected %b",
                                                  pattern_overflow, want.overflow));
                end
            end
            if (in_valid && !in_stall)
            begin
                case (op)
                    OP_CLEAR:
                    begin
                        pat_len = 0;
                        ovf     = 1'b0;
                        live    = START;
                    end
                    OP_APPEND:
                    begin
                        if (pat_len < DEPTH)
                        begin
                            pat_mem[pat_len] = ch;
                            pat_len++;
                        end
                        else
                            ovf = 1'b1;
                        live = START;
                    end
                    OP_EMPTY:
                    begin
                        expected_verdicts.push_back(subject_verdict(START));
                        live = START;
                    end
                    default:
                    begin
                        live = advance_live(ch);
                        if (last)
                        begin
                            expected_verdicts.push_back(subject_verdict(live));
                            live = START;
                        end
                    end
                endcase
            end
            pending = expected_verdicts.size();
        end
    end

endmodule

FILE: tb/tb_glob_wildcard_matcher_unit.sv
// tb_glob_wildcard_matcher_unit: drives patterns and subject strings into the matcher
// under several idle and stall mixes and gives the verdict.
// Depends on gwm_pkg, glob_wildcard_matcher_unit and gwm_match_checker.
`timescale 1ns / 100ps
module tb_glob_wildcard_matcher_unit;
    import gwm_pkg::*;

    localparam int unsigned PHASE_ITEMS = 250;
    localparam logic [7:0]  LIT_A       = 8'h61;
    localparam logic [7:0]  LIT_B       = 8'h62;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  op        = OP_CLEAR;
    logic [7:0]  ch        = 8'h00;
    logic        last      = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        matched;
    logic        pattern_overflow;
    int          fail_count;
    int          pending;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_arm       = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned n_sent         = 0;
    logic [7:0]  pat_q[$];
    logic [7:0]  subj_q[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    glob_wildcard_matcher_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .ch               (ch),
        .last             (last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

    gwm_match_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .op               (op),
        .ch               (ch),
        .last             (last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .matched          (matched),
        .pattern_overflow (pattern_overflow),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // receiver: random stall, or a long hold-off when armed
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm)
        begin
            out_stall <= 1'b1;
            hold_left <= 400;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_req(input op_t o, input logic [7:0] c, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        ch       <= c;
        last     <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte(input bit allow_wild);
        int unsigned r;
        r = $urandom_range(99);
        if (allow_wild && r < 20)
            return STAR_BYTE;
        if (allow_wild && r < 35)
            return QMARK_BYTE;
        if (r < 85)
            return r[0] ? LIT_A : LIT_B;
        return 8'($urandom_range(255));
    endfunction

    task automatic load_pattern(input int unsigned len);
        pat_q.delete();
        repeat (len)
            pat_q.push_back(pick_byte(1'b1));
        send_req(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
        foreach (pat_q[i])
            send_req(OP_APPEND, pat_q[i], 1'($urandom_range(1)));
    endtask

    // subject that fits the pattern, then sometimes damaged by one edit
    task automatic make_subject();
        subj_q.delete();
        foreach (pat_q[i])
        begin
            if (pat_q[i] == STAR_BYTE)
                repeat ($urandom_range(3))
                    subj_q.push_back(pick_byte(1'b0));
            else if (pat_q[i] == QMARK_BYTE)
                subj_q.push_back(pick_byte(1'b0));
            else
                subj_q.push_back(pat_q[i]);
        end
        case ($urandom_range(5))
            0: if (subj_q.size() != 0)
                   subj_q[$urandom_range(subj_q.size() - 1)] = pick_byte(1'b0);
            1: subj_q.push_back(pick_byte(1'b0));
            2: if (subj_q.size() != 0)
                   subj_q.delete($urandom_range(subj_q.size() - 1));
            default: ;
        endcase
    endtask

    task automatic random_phase();
        int unsigned stop_at;
        int unsigned sel;
        op_t         o;
        logic [7:0]  c;
        stop_at = n_sent + PHASE_ITEMS;
        load_pattern($urandom_range(63, 66));
        while (n_sent < stop_at)
        begin
            sel = $urandom_range(99);
            if (sel < 20)
                load_pattern(($urandom_range(9) == 0) ? $urandom_range(60, 70)
                                                       : $urandom_range(8));
            else if (sel < 85)
            begin
                make_subject();
                if (subj_q.size() == 0)
                    send_req(OP_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
                else
                    foreach (subj_q[i])
                        send_req(OP_SUBJECT, subj_q[i], i == subj_q.size() - 1);
            end
            else if (sel < 93)
            begin
                // subject cut short by an empty query or a pattern append
                make_subject();
                for (int i = 0; i + 1 < subj_q.size(); i++)
                    send_req(OP_SUBJECT, subj_q[i], 1'b0);
                if ($urandom_range(1))
                    send_req(OP_EMPTY, 8'($urandom_range(255)), 1'($urandom_range(1)));
                else
                begin
                    c = pick_byte(1'b1);
                    pat_q.push_back(c);
                    send_req(OP_APPEND, c, 1'($urandom_range(1)));
                end
            end
            else
            begin
                o = op_t'($urandom_range(3));
                c = pick_byte(1'b1);
                if (o == OP_CLEAR)
                    pat_q.delete();
                if (o == OP_APPEND)
                    pat_q.push_back(c);
                send_req(o, c, 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(OP_EMPTY, 8'hFF, 1'b1);
        send_req(OP_SUBJECT, 8'h00, 1'b1);
        send_req(OP_CLEAR, 8'h00, 1'b0);
        send_req(OP_APPEND, STAR_BYTE, 1'b1);
        send_req(OP_APPEND, STAR_BYTE, 1'b0);
        send_req(OP_EMPTY, 8'h00, 1'b0);
        send_req(OP_APPEND, QMARK_BYTE, 1'b0);
        send_req(OP_EMPTY, 8'h55, 1'b0);
        send_req(OP_SUBJECT, 8'hFF, 1'b0);
        send_req(OP_SUBJECT, 8'h00, 1'b1);
        send_req(OP_CLEAR, 8'hFF, 1'b1);
        send_req(OP_APPEND, LIT_A, 1'b0);
        send_req(OP_SUBJECT, LIT_A, 1'b0);
        send_req(OP_EMPTY, 8'hAA, 1'b1);
        send_req(OP_SUBJECT, LIT_B, 1'b0);
        send_req(OP_SUBJECT, LIT_A, 1'b0);
        send_req(OP_SUBJECT, LIT_A, 1'b1);
        send_req(OP_SUBJECT, LIT_A, 1'b0);
        send_req(OP_APPEND, 8'hFF, 1'b1);
        send_req(OP_SUBJECT, LIT_A, 1'b0);
        send_req(OP_SUBJECT, 8'hFF, 1'b1);
        send_req(OP_SUBJECT, LIT_A, 1'b1);
        pat_q.delete();
        pat_q.push_back(LIT_A);
        pat_q.push_back(8'hFF);
        wait_drained();

        // no idling, with one long receiver hold-off at the start
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
        random_phase();
        wait_drained();

        send_idle_pct = 75;
        random_phase();

        send_idle_pct = 0;
        recv_stall_pct <= 75;
        random_phase();

        send_idle_pct = 36;
        recv_stall_pct <= 36;
        random_phase();

        wait_drained();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
